### src/lcd_page_packer_writer_defines.svh
// Assertion macros shared by the checker.
`ifndef LCD_PAGE_PACKER_WRITER_DEFINES_SVH
`define LCD_PAGE_PACKER_WRITER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LPPW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LPPW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define LPPW_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lcdppw_pkg.sv
package lcdppw_pkg;

  localparam int unsigned PIXEL_W = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STORE_W = 7;
  localparam int unsigned REG_IDX_W = 2;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [STORE_W-1:0] store_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COLUMN_OFFSET      = 2'd0,
    REG_COLUMN_HIGH_OPCODE = 2'd1,
    REG_COLUMN_LOW_OPCODE  = 2'd2,
    REG_PAGE_OPCODE        = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    SLOT_COL_HIGH = 2'd0,
    SLOT_COL_LOW  = 2'd1,
    SLOT_PAGE     = 2'd2,
    SLOT_DATA     = 2'd3
  } slot_t;

  localparam byte_t COLUMN_OFFSET_RST      = 8'h1E;
  localparam byte_t COLUMN_HIGH_OPCODE_RST = 8'h10;
  localparam byte_t COLUMN_LOW_OPCODE_RST  = 8'h00;
  localparam byte_t PAGE_OPCODE_RST        = 8'hB0;
  localparam byte_t NIBBLE_MASK            = 8'h0F;

  localparam logic [2:0] LAST_ROW_BIT = 3'd7;

endpackage

### src/lcdppw_if.sv
interface lcdppw_pixel_if;
  logic                              valid;
  logic                              ready;
  logic [lcdppw_pkg::PIXEL_W-1:0]    pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface lcdppw_byte_if;
  logic                  valid;
  logic                  ready;
  lcdppw_pkg::byte_t     out_byte;
  logic                  is_data;
  logic                  last_of_run;

  modport source (output valid, output out_byte, output is_data, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input is_data, input last_of_run,
                  output ready);
endinterface

### src/lcd_page_packer_writer.sv
// Page-mode LCD write packer. Pixels arrive on pix, one per transfer, in
// row-major order over a frame WIDTH columns wide and PAGES*8 rows high; a
// nonzero pixel is lit. Controller traffic leaves on lcd, one byte per transfer.
// Rows 0 to 6 of a page are merged into a per-column line store by a
// read-modify-write; such a pixel produces no output and is taken every cycle
// unless an eighth-row pixel ahead of it waits for the output. A pixel of a
// page's eighth row produces four bytes: column-high, column-low and page
// commands, then the packed data byte flagged with is_data and last_of_run.
// The run moves from the s1 registers into the emit_bytes registers and
// leaves one byte at a time, with the next pixel already accepted while a run
// drains. Reset clears the position counters, the pipeline and the output,
// and loads the default register values; the line store is not cleared, since
// every bit of an entry is written in a page before it is packed. Configuration
// is written via cfg_we, cfg_index and cfg_data while the block is idle, a rule
// for the user that the block does not enforce. When the receiver stalls, the
// current byte holds and input stops once a second run is ready.
module lcd_page_packer_writer #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned PAGES = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [lcdppw_pkg::REG_IDX_W-1:0]      cfg_index,
  input  lcdppw_pkg::byte_t                     cfg_data,
  lcdppw_pixel_if.sink                          pix,
  lcdppw_byte_if.source                         lcd
);

  localparam int unsigned CW  = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int unsigned PGW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam logic [CW-1:0]  LAST_COL  = CW'(WIDTH - 1);
  localparam logic [PGW-1:0] LAST_PAGE = PGW'(PAGES - 1);

  lcdppw_pkg::byte_t column_offset;
  lcdppw_pkg::byte_t column_high_opcode;
  lcdppw_pkg::byte_t column_low_opcode;
  lcdppw_pkg::byte_t page_opcode;

  logic [CW-1:0]  col_cnt;
  logic [2:0]     bit_cnt;
  logic [PGW-1:0] page_cnt;

  logic           s1_valid;
  logic [CW-1:0]  s1_col;
  logic [2:0]     s1_bit;
  logic [PGW-1:0] s1_page;
  logic           s1_lit;

  lcdppw_pkg::store_t row_store [WIDTH];
  lcdppw_pkg::store_t rd_data;
  lcdppw_pkg::store_t wr_data;
  lcdppw_pkg::store_t bit_mask;

  logic               emit_busy;
  lcdppw_pkg::slot_t  emit_slot;
  lcdppw_pkg::byte_t  emit_bytes [4];

  logic in_fire;
  logic out_fire;
  logic emit_done;
  logic emit_free;
  logic s1_store;
  logic s1_pack;
  logic s1_adv;
  logic forward;

  lcdppw_pkg::byte_t col_addr;
  lcdppw_pkg::byte_t packed_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_offset      <= lcdppw_pkg::COLUMN_OFFSET_RST;
      column_high_opcode <= lcdppw_pkg::COLUMN_HIGH_OPCODE_RST;
      column_low_opcode  <= lcdppw_pkg::COLUMN_LOW_OPCODE_RST;
      page_opcode        <= lcdppw_pkg::PAGE_OPCODE_RST;
    end else if (cfg_we) begin
      unique case (lcdppw_pkg::reg_idx_t'(cfg_index))
        lcdppw_pkg::REG_COLUMN_OFFSET:      column_offset      <= cfg_data;
        lcdppw_pkg::REG_COLUMN_HIGH_OPCODE: column_high_opcode <= cfg_data;
        lcdppw_pkg::REG_COLUMN_LOW_OPCODE:  column_low_opcode  <= cfg_data;
        lcdppw_pkg::REG_PAGE_OPCODE:        page_opcode        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_fire  = lcd.valid && lcd.ready;
  assign emit_done = out_fire && (emit_slot == lcdppw_pkg::SLOT_DATA);
  assign emit_free = !emit_busy || emit_done;
  assign s1_store  = s1_valid && (s1_bit != lcdppw_pkg::LAST_ROW_BIT);
  assign s1_pack   = s1_valid && (s1_bit == lcdppw_pkg::LAST_ROW_BIT) && emit_free;
  assign s1_adv    = s1_store || s1_pack;
  assign pix.ready = !s1_valid || s1_adv;
  assign in_fire   = pix.valid && pix.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      bit_cnt  <= '0;
      page_cnt <= '0;
    end else if (in_fire) begin
      if (col_cnt == LAST_COL) begin
        col_cnt <= '0;
        bit_cnt <= bit_cnt + 3'd1;
        if (bit_cnt == lcdppw_pkg::LAST_ROW_BIT) begin
          page_cnt <= (page_cnt == LAST_PAGE) ? '0 : page_cnt + PGW'(1);
        end
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col  <= col_cnt;
      s1_bit  <= bit_cnt;
      s1_page <= page_cnt;
      s1_lit  <= (pix.pixel_value != '0);
    end
  end

  // A write in flight to the column being read is forwarded into the read register.
  assign bit_mask = lcdppw_pkg::STORE_W'(1) << s1_bit;
  assign wr_data  = s1_lit ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
  assign forward  = s1_store && (s1_col == col_cnt);

  always_ff @(posedge clk) begin
    if (s1_store) begin
      row_store[s1_col] <= wr_data;
    end
    if (in_fire) begin
      rd_data <= forward ? wr_data : row_store[col_cnt];
    end
  end

  assign col_addr    = column_offset + lcdppw_pkg::BYTE_W'(s1_col);
  assign packed_byte = {s1_lit, rd_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_busy <= 1'b0;
      emit_slot <= lcdppw_pkg::SLOT_COL_HIGH;
    end else if (s1_pack) begin
      emit_busy <= 1'b1;
      emit_slot <= lcdppw_pkg::SLOT_COL_HIGH;
    end else if (emit_done) begin
      emit_busy <= 1'b0;
    end else if (out_fire) begin
      emit_slot <= lcdppw_pkg::slot_t'(emit_slot + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_pack) begin
      emit_bytes[lcdppw_pkg::SLOT_COL_HIGH] <= column_high_opcode | {4'h0, col_addr[7:4]};
      emit_bytes[lcdppw_pkg::SLOT_COL_LOW]  <= column_low_opcode | {4'h0, col_addr[3:0]};
      emit_bytes[lcdppw_pkg::SLOT_PAGE]     <= page_opcode
                                               | (lcdppw_pkg::BYTE_W'(s1_page)
                                                  & lcdppw_pkg::NIBBLE_MASK);
      emit_bytes[lcdppw_pkg::SLOT_DATA]     <= packed_byte;
    end
  end

  assign lcd.valid       = emit_busy;
  assign lcd.out_byte    = emit_bytes[emit_slot];
  assign lcd.is_data     = (emit_slot == lcdppw_pkg::SLOT_DATA);
  assign lcd.last_of_run = (emit_slot == lcdppw_pkg::SLOT_DATA);

endmodule

### src/lcdppw_checker.sv
`include "lcd_page_packer_writer_defines.svh"

module lcdppw_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input lcdppw_pkg::byte_t out_byte,
  input logic              is_data,
  input logic              last_of_run
);

  logic [1:0] run_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_pos <= '0;
    end else if (out_valid && out_ready) begin
      run_pos <= run_pos + 2'd1;
    end
  end

  `LPPW_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_byte), "output dropped or changed while stalled")
  `LPPW_ASSERT_ALWAYS(a_reset_idle, rst, !out_valid, "output valid right after reset")
  `LPPW_ASSERT_NOW(a_run_position, out_valid, is_data == (run_pos == 2'd3), "data byte not fourth of its run")
  `LPPW_ASSERT_NOW(a_last_on_data, out_valid, last_of_run == is_data, "run end flag not on the data byte")

endmodule

bind lcd_page_packer_writer lcdppw_checker u_lcdppw_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (lcd.valid),
  .out_ready   (lcd.ready),
  .out_byte    (lcd.out_byte),
  .is_data     (lcd.is_data),
  .last_of_run (lcd.last_of_run)
);

### bench/lcd_page_packer_writer_tb.sv
module lcd_page_packer_writer_tb;

  localparam int PIX_COLS = 128;
  localparam int PIX_PAGES = 8;
  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 7;
  localparam int IDLE_PCT = 28;
  localparam int RANDOM_PAGES = 10;
  localparam int NO_IDLE_PAGE = 2;
  localparam int HOLD_AT_BYTE = 4 * PIX_COLS * 3 + 100;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT = 50000;
  localparam int TIMEOUT_CYCLES = 600000;

  typedef struct packed {
    lcdppw_pkg::byte_t value;
    logic              is_data;
    logic              last_of_run;
  } lcd_byte_t;

  typedef struct packed {
    logic [15:0] count;
    logic [15:0] value;
    logic        typed;
    logic [31:0] run;
  } seg_t;

  // Page 0 after reset: rows 0 and 6 lit, rows 1 to 5 dark, then the eighth row.
  // Runs are column-high, column-low, page and data bytes, most significant first.
  localparam int DIRECTED_ROWS = 8;
  localparam seg_t DIRECTED [DIRECTED_ROWS] = '{
    '{16'd128, 16'hFFFF, 1'b0, 32'h0},
    '{16'd640, 16'h0000, 1'b0, 32'h0},
    '{16'd128, 16'h4000, 1'b0, 32'h0},
    '{16'd1,   16'h0001, 1'b1, 32'h110E_B0C1},
    '{16'd1,   16'h8000, 1'b1, 32'h110F_B0C1},
    '{16'd1,   16'h0000, 1'b1, 32'h1200_B041},
    '{16'd124, 16'hFFFF, 1'b0, 32'h0},
    '{16'd1,   16'h00FF, 1'b1, 32'h190D_B0C1}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [lcdppw_pkg::REG_IDX_W-1:0] cfg_index;
  lcdppw_pkg::byte_t cfg_data;

  lcdppw_pixel_if pix_ch ();
  lcdppw_byte_if  lcd_ch ();

  lcd_page_packer_writer #(
    .WIDTH(PIX_COLS),
    .PAGES(PIX_PAGES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix      (pix_ch),
    .lcd      (lcd_ch)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  lcdppw_pkg::store_t lit_rows [PIX_COLS];
  int unsigned pixel_col;
  int unsigned pixel_row;
  lcdppw_pkg::byte_t col_offset_q;
  lcdppw_pkg::byte_t col_high_op_q;
  lcdppw_pkg::byte_t col_low_op_q;
  lcdppw_pkg::byte_t page_op_q;

  lcd_byte_t pending_bytes [$];
  lcd_byte_t wanted_byte;
  int unsigned bytes_seen = 0;
  int mismatches = 0;
  bit no_idle = 1'b0;
  bit held_off = 1'b0;

  task automatic report_mismatch(input string what);
    $display("[%0t] byte %0d: %s", $time, bytes_seen, what);
    mismatches++;
  endtask

  task automatic pack_pixel(input logic [15:0] value, input logic typed,
                            input logic [31:0] typed_run);
    logic lit;
    int unsigned row_in_page;
    int unsigned page_num;
    lcdppw_pkg::byte_t addr;
    logic [31:0] run;
    lit = (value != 16'h0);
    row_in_page = pixel_row % 8;
    page_num = pixel_row / 8;
    if (row_in_page != lcdppw_pkg::LAST_ROW_BIT) begin
      lit_rows[pixel_col][row_in_page] = lit;
    end else begin
      addr = col_offset_q + lcdppw_pkg::byte_t'(pixel_col);
      run = {col_high_op_q | (addr >> 4),
             col_low_op_q | (addr & lcdppw_pkg::NIBBLE_MASK),
             page_op_q | (lcdppw_pkg::byte_t'(page_num) & lcdppw_pkg::NIBBLE_MASK),
             lit, lit_rows[pixel_col]};
      if (typed) begin
        run = typed_run;
      end
      pending_bytes.push_back({run[31:24], 2'b00});
      pending_bytes.push_back({run[23:16], 2'b00});
      pending_bytes.push_back({run[15:8], 2'b00});
      pending_bytes.push_back({run[7:0], 2'b11});
    end
    pixel_col++;
    if (pixel_col >= PIX_COLS) begin
      pixel_col = 0;
      pixel_row++;
      if (pixel_row >= PIX_PAGES * 8) begin
        pixel_row = 0;
      end
    end
  endtask

  task automatic send_pixel(input logic [15:0] value, input logic typed,
                            input logic [31:0] typed_run);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel_value <= value;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    pack_pixel(value, typed, typed_run);
    @(negedge clk);
  endtask

  task automatic write_reg(input lcdppw_pkg::reg_idx_t idx, input lcdppw_pkg::byte_t value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      lcdppw_pkg::REG_COLUMN_OFFSET: col_offset_q = value;
      lcdppw_pkg::REG_COLUMN_HIGH_OPCODE: col_high_op_q = value;
      lcdppw_pkg::REG_COLUMN_LOW_OPCODE: col_low_op_q = value;
      lcdppw_pkg::REG_PAGE_OPCODE: page_op_q = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Page 1 takes all zeros, page 2 all ones, the rest random settings.
  function automatic lcdppw_pkg::byte_t phase_setting(input int page);
    if (page == 1) return 8'h00;
    if (page == 2) return 8'hFF;
    return lcdppw_pkg::byte_t'($urandom_range(255));
  endfunction

  function automatic logic [15:0] random_pixel();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) return 16'h0000;
    if (pick < 60) return 16'h0001 << $urandom_range(15);
    return 16'($urandom);
  endfunction

  always @(posedge clk) begin
    if (!rst && lcd_ch.valid && lcd_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", lcd_ch.out_byte));
      end else begin
        wanted_byte = pending_bytes.pop_front();
        if (lcd_ch.out_byte !== wanted_byte.value) begin
          report_mismatch($sformatf("out_byte %02h, wanted %02h",
                                    lcd_ch.out_byte, wanted_byte.value));
        end
        if (lcd_ch.is_data !== wanted_byte.is_data) begin
          report_mismatch($sformatf("is_data %b, wanted %b",
                                    lcd_ch.is_data, wanted_byte.is_data));
        end
        if (lcd_ch.last_of_run !== wanted_byte.last_of_run) begin
          report_mismatch($sformatf("last_of_run %b, wanted %b",
                                    lcd_ch.last_of_run, wanted_byte.last_of_run));
        end
      end
      bytes_seen++;
    end
  end

  // The receiver stalls once for a long stretch while the eighth row of a page drains.
  initial begin
    lcd_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && bytes_seen >= HOLD_AT_BYTE) begin
        held_off = 1'b1;
        lcd_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        lcd_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("[lcd_page_packer_writer] ERROR");
    $finish;
  end

  initial begin
    int drain;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = lcdppw_pkg::REG_COLUMN_OFFSET;
    cfg_data = 8'h00;
    pix_ch.valid = 1'b0;
    pix_ch.pixel_value = 16'h0000;
    pixel_col = 0;
    pixel_row = 0;
    col_offset_q = lcdppw_pkg::COLUMN_OFFSET_RST;
    col_high_op_q = lcdppw_pkg::COLUMN_HIGH_OPCODE_RST;
    col_low_op_q = lcdppw_pkg::COLUMN_LOW_OPCODE_RST;
    page_op_q = lcdppw_pkg::PAGE_OPCODE_RST;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      for (int n = 0; n < DIRECTED[r].count; n++) begin
        send_pixel(DIRECTED[r].value, DIRECTED[r].typed, DIRECTED[r].run);
      end
    end

    // Each later page starts from an idle block with a fresh register setting.
    for (int page = 1; page <= RANDOM_PAGES; page++) begin
      pix_ch.valid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
      write_reg(lcdppw_pkg::REG_COLUMN_OFFSET, phase_setting(page));
      write_reg(lcdppw_pkg::REG_COLUMN_HIGH_OPCODE, phase_setting(page));
      write_reg(lcdppw_pkg::REG_COLUMN_LOW_OPCODE, phase_setting(page));
      write_reg(lcdppw_pkg::REG_PAGE_OPCODE, phase_setting(page));
      cfg_we <= 1'b0;
      no_idle = (page == NO_IDLE_PAGE);
      for (int n = 0; n < PIX_COLS * 8; n++) begin
        send_pixel(random_pixel(), 1'b0, 32'h0);
      end
    end
    pix_ch.valid <= 1'b0;
    no_idle = 1'b0;

    drain = 0;
    while (pending_bytes.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    if (pending_bytes.size() != 0) begin
      report_mismatch($sformatf("%0d bytes never arrived", pending_bytes.size()));
    end
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    if (mismatches == 0) begin
      $display("[lcd_page_packer_writer] OK");
    end else begin
      $display("[lcd_page_packer_writer] ERROR");
    end
    $finish;
  end

endmodule
